>>> sv/jcbp_pkg.sv
// ----------------------------------------------------------------------------
// jcbp_pkg: shared types and constants for the joystick command byte parser
// Character codes, axis selector codes and the result record.
// ----------------------------------------------------------------------------
package jcbp_pkg;

  localparam int BYTE_W   = 8;
  localparam int OFFSET_W = 14;
  localparam int POS_W    = 15;
  localparam int POS_LIMIT = 16383;

  localparam logic [BYTE_W-1:0] CH_PAD_FIRST = 8'h41;  // 'A'
  localparam logic [BYTE_W-1:0] CH_PAD_LAST  = 8'h48;  // 'H'
  localparam logic [BYTE_W-1:0] CH_STOP      = 8'h53;  // 'S'
  localparam logic [BYTE_W-1:0] CH_MODE      = 8'h4D;  // 'M'
  localparam logic [BYTE_W-1:0] CH_OPEN      = 8'h2A;  // '*'
  localparam logic [BYTE_W-1:0] CH_CLOSE     = 8'h5F;  // '_'
  localparam logic [BYTE_W-1:0] CH_AXIS_X    = 8'h58;  // 'X'
  localparam logic [BYTE_W-1:0] CH_AXIS_Y    = 8'h59;  // 'Y'
  localparam logic [BYTE_W-1:0] CH_DIGIT_0   = 8'h30;  // '0'
  localparam logic [BYTE_W-1:0] CH_DIGIT_9   = 8'h39;  // '9'

  localparam logic [1:0] AXIS_NONE = 2'd0;
  localparam logic [1:0] AXIS_X    = 2'd1;
  localparam logic [1:0] AXIS_Y    = 2'd2;

  // pad direction: 2'b01 = +P, 2'b11 = -P, 2'b00 = 0
  localparam logic [1:0] DIR_ZERO = 2'b00;
  localparam logic [1:0] DIR_POS  = 2'b01;
  localparam logic [1:0] DIR_NEG  = 2'b11;

  typedef struct packed {
    logic signed [POS_W-1:0] x_position;
    logic signed [POS_W-1:0] y_position;
    logic                    update_motors;
    logic                    mode_toggle;
  } result_t;

  // compass point of pad letter, index 0 = 'A' (east), counter-clockwise
  function automatic logic [1:0] pad_dx(input logic [2:0] idx);
    case (idx)
      3'd0, 3'd1, 3'd7: pad_dx = DIR_POS;
      3'd3, 3'd4, 3'd5: pad_dx = DIR_NEG;
      default:          pad_dx = DIR_ZERO;
    endcase
  endfunction

  function automatic logic [1:0] pad_dy(input logic [2:0] idx);
    case (idx)
      3'd1, 3'd2, 3'd3: pad_dy = DIR_POS;
      3'd5, 3'd6, 3'd7: pad_dy = DIR_NEG;
      default:          pad_dy = DIR_ZERO;
    endcase
  endfunction

endpackage

>>> sv/joystick_command_byte_parser.sv
// ----------------------------------------------------------------------------
// joystick_command_byte_parser: serial command byte to motor target parser
// Stream in one received byte per beat, stream out target updates.
// ----------------------------------------------------------------------------
// Takes one received byte per beat and gives at most one result beat per
// byte. Each byte lands in an input register, is decoded by a single level
// of logic against the parser state and, when it yields a result, lands in
// the output register, which holds it while the output side stalls. One
// byte is accepted every cycle as long as the output side keeps draining.
// Pad letters A..H set the target to a compass point with each nonzero axis
// of magnitude center_offset, 'S' stops (target 0,0, no update), 'M' flags a
// mode toggle, '*' opens a joystick frame that closes on '_' with X/Y set to
// 4*value - center_offset, clamped to +/-16383. Bytes inside a frame give no
// result beat except the closing '_'. center_offset is written through
// cfg_wr_en/cfg_wr_data and should only change while the block is idle.
module joystick_command_byte_parser
  import jcbp_pkg::*;
#(
  parameter int VALUE_BITS = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [OFFSET_W-1:0] cfg_wr_data,     // center_offset
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,    // [7:0] rx_byte
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [31:0]         m_axis_tdata,    // [14:0] x_position, [29:15] y_position
  output logic [1:0]          m_axis_tuser     // [0] update_motors, [1] mode_toggle
);

  logic [OFFSET_W-1:0] center_offset;
  logic                in_valid;
  logic [BYTE_W-1:0]   in_byte;
  logic                out_free;
  logic                fire;
  logic                res_valid;
  result_t             res;
  result_t             out_res;

  // output slot free when empty or being taken this cycle
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign fire          = in_valid && out_free;
  assign s_axis_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_offset <= OFFSET_W'(510);
    end else if (cfg_wr_en) begin
      center_offset <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  jcbp_core #(
    .VALUE_BITS (VALUE_BITS)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .rx_byte       (in_byte),
    .center_offset (center_offset),
    .res_valid     (res_valid),
    .res           (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {2'b00, out_res.y_position, out_res.x_position};
  assign m_axis_tuser = {out_res.mode_toggle, out_res.update_motors};

`ifndef SYNTH
  // a mode toggle never drives the motors
  a_mode_no_update: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0])
    else $error("mode toggle beat with motor update");

  // clamp keeps positions off the most negative code
  a_pos_clamped: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[14:0] != 15'h4000)
                      && (m_axis_tdata[29:15] != 15'h4000))
    else $error("position outside clamp range");

  // input side stalls only while a byte waits on a blocked output slot
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> in_valid && m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without cause");

  // a byte that yields no result leaves the output slot empty behind it
  a_no_result: assert property (@(posedge clk) disable iff (rst)
    fire && !res_valid |=> !m_axis_tvalid)
    else $error("result beat without producing byte");
`endif

endmodule

>>> sv/jcbp_core.sv
// ----------------------------------------------------------------------------
// jcbp_core: command decode and parser state
// Decodes one registered byte per fire, updates frame and target state and
// presents the result combinationally for the output register.
// ----------------------------------------------------------------------------
module jcbp_core
  import jcbp_pkg::*;
#(
  parameter int VALUE_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  logic [BYTE_W-1:0]     rx_byte,
  input  logic [OFFSET_W-1:0]   center_offset,
  output logic                  res_valid,
  output result_t               res
);

  localparam int SW = (VALUE_BITS + 3 > POS_W) ? VALUE_BITS + 3 : POS_W;
  localparam int MW = VALUE_BITS + 4;
  localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};

  logic                    in_frame, in_frame_next;
  logic [1:0]              active_axis, active_axis_next;
  logic                    x_found, x_found_next;
  logic                    y_found, y_found_next;
  logic [VALUE_BITS-1:0]   x_accum, x_accum_next;
  logic [VALUE_BITS-1:0]   y_accum, y_accum_next;
  logic signed [POS_W-1:0] held_x, held_x_next;
  logic signed [POS_W-1:0] held_y, held_y_next;

  logic                    is_digit;
  logic [VALUE_BITS-1:0]   acc_sel, acc_added;
  logic [MW-1:0]           acc_wide;
  logic signed [POS_W-1:0] p_pos, p_neg;
  logic [2:0]              pad_idx;

  function automatic logic signed [POS_W-1:0] scale_axis(
    input logic [VALUE_BITS-1:0] value,
    input logic [OFFSET_W-1:0]   p
  );
    logic signed [SW-1:0] v;
    v = $signed({{(SW-VALUE_BITS-2){1'b0}}, value, 2'b00})
        - $signed({{(SW-OFFSET_W){1'b0}}, p});
    if (v > $signed(SW'(POS_LIMIT)))
      scale_axis = POS_W'(POS_LIMIT);
    else if (v < -$signed(SW'(POS_LIMIT)))
      scale_axis = -$signed(POS_W'(POS_LIMIT));
    else
      scale_axis = v[POS_W-1:0];
  endfunction

  function automatic logic signed [POS_W-1:0] pad_value(
    input logic [1:0]              dir,
    input logic signed [POS_W-1:0] pp,
    input logic signed [POS_W-1:0] pn
  );
    case (dir)
      DIR_POS: pad_value = pp;
      DIR_NEG: pad_value = pn;
      default: pad_value = '0;
    endcase
  endfunction

  // one shared digit step: acc*10 + digit, saturating
  assign is_digit  = (rx_byte inside {[CH_DIGIT_0:CH_DIGIT_9]});
  assign acc_sel   = (active_axis == AXIS_Y) ? y_accum : x_accum;
  assign acc_wide  = {1'b0, acc_sel, 3'b000} + {3'b000, acc_sel, 1'b0}
                     + {{(MW-4){1'b0}}, rx_byte[3:0]};
  assign acc_added = (acc_wide > {4'b0000, VALUE_MAX}) ? VALUE_MAX
                                                       : acc_wide[VALUE_BITS-1:0];

  assign p_pos   = $signed({1'b0, center_offset});
  assign p_neg   = -p_pos;
  assign pad_idx = rx_byte[2:0] - CH_PAD_FIRST[2:0];

  always_comb begin
    in_frame_next    = in_frame;
    active_axis_next = active_axis;
    x_found_next     = x_found;
    y_found_next     = y_found;
    x_accum_next     = x_accum;
    y_accum_next     = y_accum;
    held_x_next      = held_x;
    held_y_next      = held_y;
    res_valid        = 1'b1;
    res.update_motors = 1'b1;
    res.mode_toggle   = 1'b0;

    if (in_frame) begin
      res_valid = 1'b0;
      if (is_digit) begin
        if (active_axis == AXIS_X) x_accum_next = acc_added;
        else if (active_axis == AXIS_Y) y_accum_next = acc_added;
      end else begin
        active_axis_next = AXIS_NONE;
        if (rx_byte == CH_AXIS_X) begin
          if (!x_found) begin
            x_found_next     = 1'b1;
            x_accum_next     = '0;
            active_axis_next = AXIS_X;
          end
        end else if (rx_byte == CH_AXIS_Y) begin
          if (!y_found) begin
            y_found_next     = 1'b1;
            y_accum_next     = '0;
            active_axis_next = AXIS_Y;
          end
        end else if (rx_byte == CH_CLOSE) begin
          res_valid     = 1'b1;
          in_frame_next = 1'b0;
          held_x_next   = scale_axis(x_found ? x_accum : '0, center_offset);
          held_y_next   = scale_axis(y_found ? y_accum : '0, center_offset);
        end
      end
    end else if (rx_byte inside {[CH_PAD_FIRST:CH_PAD_LAST]}) begin
      held_x_next = pad_value(pad_dx(pad_idx), p_pos, p_neg);
      held_y_next = pad_value(pad_dy(pad_idx), p_pos, p_neg);
    end else if (rx_byte == CH_STOP) begin
      held_x_next       = '0;
      held_y_next       = '0;
      res.update_motors = 1'b0;
    end else if (rx_byte == CH_MODE) begin
      res.update_motors = 1'b0;
      res.mode_toggle   = 1'b1;
    end else if (rx_byte == CH_OPEN) begin
      res_valid        = 1'b0;
      in_frame_next    = 1'b1;
      active_axis_next = AXIS_NONE;
      x_found_next     = 1'b0;
      y_found_next     = 1'b0;
      x_accum_next     = '0;
      y_accum_next     = '0;
    end

    res.x_position = held_x_next;
    res.y_position = held_y_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame    <= 1'b0;
      active_axis <= AXIS_NONE;
      x_found     <= 1'b0;
      y_found     <= 1'b0;
      x_accum     <= '0;
      y_accum     <= '0;
      held_x      <= '0;
      held_y      <= '0;
    end else if (fire) begin
      in_frame    <= in_frame_next;
      active_axis <= active_axis_next;
      x_found     <= x_found_next;
      y_found     <= y_found_next;
      x_accum     <= x_accum_next;
      y_accum     <= y_accum_next;
      held_x      <= held_x_next;
      held_y      <= held_y_next;
    end
  end

endmodule
